// ===== hw/rtl/rth_pkg.sv =====
// Package for the 8-bit RGB to HSV converter.
// Holds the pipeline payload types, the fixed constants and the divider step.
// No dependencies.
package rth_pkg;

  // Channel width and the number of quotient bits, one per divider cell.
  localparam int unsigned ChW  = 8;
  localparam int unsigned QuoW = 8;

  // Hue scale: one sixth of a turn, and the base of each primary sector.
  localparam logic [ChW-1:0] HueSpan   = 8'd43;
  localparam logic [ChW-1:0] HueBaseR  = 8'd0;
  localparam logic [ChW-1:0] HueBaseG  = 8'd85;
  localparam logic [ChW-1:0] HueBaseB  = 8'd171;
  localparam logic [ChW-1:0] FullScale = 8'd255;

  // One restoring-division lane: partial remainder, numerator bits still to
  // be shifted in, divisor and the quotient collected so far.
  typedef struct packed {
    logic [ChW-1:0]  rem;
    logic [ChW-1:0]  num_lo;
    logic [ChW-1:0]  den;
    logic [QuoW-1:0] quo;
  } lane_t;

  // Everything a pixel carries down the divider chain.
  typedef struct packed {
    lane_t          sat;
    lane_t          hue;
    logic [ChW-1:0] base;
    logic           neg;
    logic           black;
    logic           grey;
    logic [ChW-1:0] value;
  } cell_t;

  // One quotient bit of restoring division. The remainder stays below the
  // divisor, so the trial value fits in nine bits.
  function automatic lane_t div_step(lane_t l);
    lane_t      n;
    logic [ChW:0] trial;
    logic [ChW:0] diff;
    logic         ge;
    trial    = {l.rem, l.num_lo[ChW-1]};
    diff     = trial - {1'b0, l.den};
    ge       = (trial >= {1'b0, l.den});
    n.rem    = ge ? diff[ChW-1:0] : trial[ChW-1:0];
    n.num_lo = {l.num_lo[ChW-2:0], 1'b0};
    n.den    = l.den;
    n.quo    = {l.quo[QuoW-2:0], ge};
    return n;
  endfunction

endpackage

// ===== hw/rtl/rth_front.sv =====
// Front stage of the RGB to HSV converter: maximum, minimum, hue sector and
// the two division numerators, registered. Depends on rth_pkg.
module rth_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               vld_o,
  output rth_pkg::cell_t     data_o
);
  import rth_pkg::*;

  logic [ChW-1:0]   mx, mn, d, op_a, op_b, mag, base;
  logic             neg;
  logic [2*ChW-1:0] sat_num, hue_num;
  cell_t            cell_d;
  cell_t            cell_q;
  logic             vld_q;

  // Largest and smallest channel, and the sector of the maximum. On a tie
  // red wins over green and green over blue.
  always_comb begin
    mx = (red_i > green_i) ? ((red_i > blue_i) ? red_i : blue_i)
                           : ((green_i > blue_i) ? green_i : blue_i);
    mn = (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                           : ((green_i < blue_i) ? green_i : blue_i);
    d  = mx - mn;
    if (mx == red_i) begin
      base = HueBaseR;
      op_a = green_i;
      op_b = blue_i;
    end else if (mx == green_i) begin
      base = HueBaseG;
      op_a = blue_i;
      op_b = red_i;
    end else begin
      base = HueBaseB;
      op_a = red_i;
      op_b = green_i;
    end
    neg = (op_a < op_b);
    mag = neg ? (op_b - op_a) : (op_a - op_b);
  end

  // Numerators. Both stay below 256 times their divisor, so the quotient
  // fits in eight bits and the upper byte is a valid starting remainder.
  always_comb begin
    sat_num = (2*ChW)'(FullScale) * (2*ChW)'(d);
    hue_num = (2*ChW)'(HueSpan) * (2*ChW)'(mag);

    cell_d.sat.rem    = sat_num[2*ChW-1:ChW];
    cell_d.sat.num_lo = sat_num[ChW-1:0];
    cell_d.sat.den    = mx;
    cell_d.sat.quo    = '0;
    cell_d.hue.rem    = hue_num[2*ChW-1:ChW];
    cell_d.hue.num_lo = hue_num[ChW-1:0];
    cell_d.hue.den    = d;
    cell_d.hue.quo    = '0;
    cell_d.base       = base;
    cell_d.neg        = neg;
    cell_d.black      = (mx == '0);
    cell_d.grey       = (d == '0);
    cell_d.value      = mx;
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = cell_q;

endmodule

// ===== hw/rtl/rth_div_cell.sv =====
// One cell of the divider chain: a quotient bit for saturation and for hue.
// Depends on rth_pkg.
module rth_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  rth_pkg::cell_t data_i,
  output logic           vld_o,
  output rth_pkg::cell_t data_o
);
  import rth_pkg::*;

  logic  vld_q;
  cell_t data_d;
  cell_t data_q;

  // Both lanes take one step; the rest of the pixel rides along.
  always_comb begin
    data_d     = data_i;
    data_d.sat = div_step(data_i.sat);
    data_d.hue = div_step(data_i.hue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== hw/rtl/rgb_to_hsv_8bit_unit.sv =====
// Top level of the 8-bit RGB to HSV converter.
// Depends on rth_pkg, rth_front and rth_div_cell.
//
// Converts one 8-bit RGB pixel to 8-bit HSV per clock. Each pixel passes ten
// register stages: one front stage for maximum, minimum and numerators, a
// chain of eight divider cells that each settle one quotient bit of both
// saturation and hue, and the output register. A pixel that waited in the
// skid register shows later, and a result held by out_stall_i stays on the
// outputs until it is taken. Throughput is one pixel per clock while the
// output is not stalled. A two-entry boundary (input skid register plus
// output register) keeps in_stall_o a registered signal.
// Hue is 43 steps per sixth of a turn, wrapped modulo 256.
module rgb_to_hsv_8bit_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] brightness_o
);
  import rth_pkg::*;

  logic           en;
  logic           skid_vld_q;
  logic [ChW-1:0] skid_r_q, skid_g_q, skid_b_q;
  logic           src_vld;
  logic [ChW-1:0] src_r, src_g, src_b;
  logic           accept;

  logic           vld [QuoW+1];
  cell_t          data [QuoW+1];

  logic           out_vld_q;
  logic [ChW-1:0] hue_d, hue_q, sat_d, sat_q, val_q;

  // The whole pipeline moves unless a result is held at the output.
  assign en     = !(out_vld_q && out_stall_i);
  assign accept = in_valid_i && !skid_vld_q;

  // Input skid register: catches the transfer made while the pipeline holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && accept) begin
      skid_r_q <= red_i;
      skid_g_q <= green_i;
      skid_b_q <= blue_i;
    end
  end

  assign in_stall_o = skid_vld_q;
  assign src_vld    = skid_vld_q || in_valid_i;
  assign src_r      = skid_vld_q ? skid_r_q : red_i;
  assign src_g      = skid_vld_q ? skid_g_q : green_i;
  assign src_b      = skid_vld_q ? skid_b_q : blue_i;

  // Front stage.
  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (src_vld),
    .red_i   (src_r),
    .green_i (src_g),
    .blue_i  (src_b),
    .vld_o   (vld[0]),
    .data_o  (data[0])
  );

  // Divider chain, one quotient bit per cell, most significant first.
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[i]),
      .data_i (data[i]),
      .vld_o  (vld[i+1]),
      .data_o (data[i+1])
    );
  end

  // Final hue and saturation: saturation forced to zero for black pixels, hue for grey or unsaturated ones.
  always_comb begin
    sat_d = data[QuoW].black ? '0 : data[QuoW].sat.quo;
    if (data[QuoW].grey || (sat_d == '0)) begin
      hue_d = '0;
    end else if (data[QuoW].neg) begin
      hue_d = data[QuoW].base - data[QuoW].hue.quo;
    end else begin
      hue_d = data[QuoW].base + data[QuoW].hue.quo;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= data[QuoW].value;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

endmodule

// ===== hw/rtl/rth_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rgb_to_hsv_8bit_unit.
module rth_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] hue_o,
  input logic [7:0] saturation_o,
  input logic [7:0] brightness_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("stalled result changed");

  // The input stalls only after taking a transfer it could not pass on.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i) && $past(out_valid_o && out_stall_i))
    else $error("input stall without a held transfer");

  // A black pixel has no saturation.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (brightness_o == 8'd0) |-> saturation_o == 8'd0)
    else $error("saturation on a black pixel");

  // Without saturation there is no hue.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_o == 8'd0) |-> hue_o == 8'd0)
    else $error("hue on an unsaturated pixel");

endmodule

bind rgb_to_hsv_8bit_unit rth_checker u_rth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .brightness_o (brightness_o)
);
